// ===== src/cvmf_pkg.sv =====
// Shared constants, latencies and coefficient functions of the valve mass flow pipeline.
`default_nettype none
package cvmf_pkg;

  // fixed-point formats
  localparam int LOG_FRAC = 24;              // fraction bits of a log2 value
  localparam int LW       = 29;              // width of a log2 value (5 int + 24 frac)
  localparam int TW       = 48;              // signed width of log sums and exponents
  localparam int EW       = 63;              // width of an exp2 result

  localparam logic [16:0] ONE_Q16  = 17'h10000;
  localparam logic [30:0] MASS_CAP = 31'h7FFF_FFFF;

  // restoring divider geometry
  localparam int DIV_NW = 48;
  localparam int DIV_DW = 17;

  // unit latencies in cycles (input register included)
  localparam int LOG_LAT = 2 + LOG_FRAC;
  localparam int EXP_LAT = 2 + LOG_FRAC;
  localparam int DIV_LAT = 1 + DIV_NW;

  // configuration register map
  localparam int          CFG_AW        = 3;
  localparam logic        REG_FLOW_AREA = 1'b0;

  // floor square root, elaboration only
  function automatic logic [63:0] isqrt64(input logic [63:0] x);
    logic [63:0] res;
    logic [63:0] bitv;
    logic [63:0] rem;
    res  = '0;
    bitv = 64'h4000_0000_0000_0000;
    rem  = x;
    for (int i = 0; i < 32; i++) begin
      if (rem >= res + bitv) begin
        rem = rem - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  // 2^(2^-(k+1)) in Q1.31, by repeated square roots starting from 2.0
  function automatic logic [31:0] exp_coef(input int k);
    logic [63:0] c;
    c = 64'h1_0000_0000;
    for (int i = 0; i <= k; i++) begin
      c = isqrt64(c << 31);
    end
    return c[31:0];
  endfunction

endpackage
`default_nettype wire

// ===== src/cvmf_dly.sv =====
// Enabled delay line used to carry side data alongside the arithmetic units.
`default_nettype none
module cvmf_dly #(
  parameter int W = 1,
  parameter int N = 1
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         en,
  input  logic [W-1:0] d,
  output logic [W-1:0] q
);

  logic [W-1:0] s_r [0:N-1];

  // shift by one tap per enabled cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < N; i++) s_r[i] <= '0;
    end else if (en) begin
      s_r[0] <= d;
      for (int i = 1; i < N; i++) s_r[i] <= s_r[i-1];
    end
  end

  assign q = s_r[N-1];

endmodule
`default_nettype wire

// ===== src/cvmf_log.sv =====
// Pipelined log2 unit: normalize, then one squaring per fraction bit.
`default_nettype none
module cvmf_log #(
  parameter int W = 32
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic [W-1:0]            x,
  output logic [cvmf_pkg::LW-1:0] lg
);

  localparam int FB = cvmf_pkg::LOG_FRAC;

  logic [31:0]   xe;
  logic [4:0]    enc;
  logic [31:0]   x_r;
  logic [4:0]    n0_r;
  logic [31:0]   y_r [0:FB];
  logic [4:0]    n_r [0:FB];
  logic [FB-1:0] f_r [0:FB];

  assign xe = 32'(x);

  // top set bit index (zero input gives zero)
  always_comb begin
    enc = '0;
    for (int i = 0; i < 32; i++) begin
      if (xe[i]) enc = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r  <= xe;
      n0_r <= enc;
    end
  end

  // normalize to Q1.31
  always_ff @(posedge clk) begin
    if (en) begin
      y_r[0] <= x_r << (5'd31 - n0_r);
      n_r[0] <= n0_r;
      f_r[0] <= '0;
    end
  end

  // one fraction bit per stage
  for (genvar k = 0; k < FB; k++) begin : g_sq
    logic [63:0] sq;
    logic [32:0] y2;
    assign sq = y_r[k] * y_r[k];
    assign y2 = sq[63:31];
    always_ff @(posedge clk) begin
      if (en) begin
        y_r[k+1] <= y2[32] ? y2[32:1] : y2[31:0];
        f_r[k+1] <= {f_r[k][FB-2:0], y2[32]};
        n_r[k+1] <= n_r[k];
      end
    end
  end

  assign lg = {n_r[FB], f_r[FB]};

endmodule
`default_nettype wire

// ===== src/cvmf_exp.sv =====
// Pipelined exp2 unit: one constant multiply per fraction bit, then a scaling shift.
`default_nettype none
module cvmf_exp #(
  parameter int VW = 48,
  parameter int S  = 0
) (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [VW-1:0]    v,
  output logic [cvmf_pkg::EW-1:0] e
);

  localparam int FB  = cvmf_pkg::LOG_FRAC;
  localparam int IW  = VW - FB;
  localparam int SHW = IW + 2;
  localparam int EW  = cvmf_pkg::EW;

  logic [31:0]          m_r [0:FB];
  logic [FB-1:0]        f_r [0:FB];
  logic signed [IW-1:0] i_r [0:FB];
  logic signed [SHW-1:0] sh;
  logic signed [SHW-1:0] nsh;
  logic [EW-1:0]        res;
  logic [EW-1:0]        e_r;

  // split into integer part (floor) and fraction
  always_ff @(posedge clk) begin
    if (en) begin
      m_r[0] <= 32'h8000_0000;
      f_r[0] <= v[FB-1:0];
      i_r[0] <= v[VW-1:FB];
    end
  end

  // multiply in 2^(bit weight) for each set fraction bit, MSB first
  for (genvar k = 0; k < FB; k++) begin : g_mul
    localparam logic [31:0] C = cvmf_pkg::exp_coef(k);
    logic [63:0] prod;
    assign prod = m_r[k] * C;
    always_ff @(posedge clk) begin
      if (en) begin
        m_r[k+1] <= f_r[k][FB-1-k] ? prod[62:31] : m_r[k];
        f_r[k+1] <= f_r[k];
        i_r[k+1] <= i_r[k];
      end
    end
  end

  // final scaling with clamp at 2^62 and flush to zero
  assign sh  = SHW'(i_r[FB]) + SHW'(S - 31);
  assign nsh = -sh;

  always_comb begin
    if (sh > 30) begin
      res = EW'(1) << 62;
    end else if (sh >= 0) begin
      res = EW'(m_r[FB]) << sh[4:0];
    end else if (sh <= -64) begin
      res = '0;
    end else begin
      res = EW'(m_r[FB]) >> nsh[5:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) e_r <= res;
  end

  assign e = e_r;

endmodule
`default_nettype wire

// ===== src/cvmf_div.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module cvmf_div #(
  parameter int NW = 48,
  parameter int DW = 17
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] n,
  input  logic [DW-1:0] d,
  output logic [NW-1:0] q
);

  logic [NW-1:0] n_r [0:NW];
  logic [DW-1:0] d_r [0:NW];
  logic [DW-1:0] r_r [0:NW];

  always_ff @(posedge clk) begin
    if (en) begin
      n_r[0] <= n;
      d_r[0] <= d;
      r_r[0] <= '0;
    end
  end

  // dividend bits shift out at the top, quotient bits in at the bottom
  for (genvar k = 0; k < NW; k++) begin : g_step
    logic [DW:0] t;
    logic [DW:0] diff;
    logic        ge;
    assign t    = {r_r[k], n_r[k][NW-1]};
    assign ge   = t >= {1'b0, d_r[k]};
    assign diff = t - {1'b0, d_r[k]};
    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k+1] <= ge ? diff[DW-1:0] : t[DW-1:0];
        n_r[k+1] <= {n_r[k][NW-2:0], ge};
        d_r[k+1] <= d_r[k];
      end
    end
  end

  assign q = n_r[NW];

endmodule
`default_nettype wire

// ===== src/compressible_valve_mass_flow.sv =====
// Top level: isentropic valve mass flow, choked and subsonic, as a deep pipeline.
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------------
//  in_      | input     | in_valid/in_stall  | up_/down_ pressure, temp, gas const, k
//  out_     | output    | out_valid/out_stall| mass_flow, is_choked, input_error
//  cfg      | input     | APB, pready high   | flow_area at byte address 0
//
// One word enters per cycle while in_stall is low. Each word passes the chain
// log2 -> divide -> exp2 -> log2 -> exp2 plus glue stages; log2 and exp2 take one
// squaring or multiply per fraction bit, the divider one quotient bit per stage. Reset
// clears the valid bits and flow_area. A stalled result freezes the whole pipeline in
// place; in_stall follows out_stall while a result waits.
`default_nettype none
module compressible_valve_mass_flow (
  input  logic                          clk,
  input  logic                          rst_n,
  // input channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [23:0]                   in_up_pressure,
  input  logic [15:0]                   in_up_temperature,
  input  logic [15:0]                   in_up_gas_constant,
  input  logic [16:0]                   in_up_heat_ratio,
  input  logic [23:0]                   in_down_pressure,
  input  logic [15:0]                   in_down_temperature,
  input  logic [15:0]                   in_down_gas_constant,
  input  logic [16:0]                   in_down_heat_ratio,
  // result channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            out_mass_flow,
  output logic                          out_is_choked,
  output logic                          out_input_error,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cvmf_pkg::CFG_AW-1:0]   paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int LW = cvmf_pkg::LW;
  localparam int TW = cvmf_pkg::TW;
  localparam int EW = cvmf_pkg::EW;
  localparam int NW = cvmf_pkg::DIV_NW;
  localparam int DW = cvmf_pkg::DIV_DW;
  localparam int L  = cvmf_pkg::LOG_LAT;
  localparam int D  = cvmf_pkg::DIV_LAT;
  localparam int E  = cvmf_pkg::EXP_LAT;

  // stage times, counted from the input register
  localparam int TL  = L;
  localparam int TD  = TL + 2 + D;
  localparam int TE  = TD + 1 + E;
  localparam int TLD = TE + 1 + L;
  localparam int TF  = TLD + 2 + E;

  logic en;

  // configuration register
  logic [31:0] area_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == cvmf_pkg::REG_FLOW_AREA);
  assign prdata = (paddr[2] == cvmf_pkg::REG_FLOW_AREA) ? area_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) area_r <= '0;
    else if (cfg_wr) area_r <= pwdata;
  end

  // global advance: the whole pipe holds while a result is stalled
  assign in_stall = out_valid & out_stall;
  assign en       = ~in_stall;

  // ---------------- input stage: validate, pick the high side ----------------
  logic        err_c, fwd_c;
  logic        s0_valid_r, s0_err_r, s0_fwd_r;
  logic [23:0] s0_p_r, s0_plo_r;
  logic [15:0] s0_t_r, s0_g_r;
  logic [16:0] s0_h_r;
  logic [17:0] s0_hp1_r;

  assign err_c = (in_up_pressure == '0) | (in_down_pressure == '0) |
                 (in_up_temperature == '0) | (in_down_temperature == '0) |
                 (in_up_gas_constant == '0) | (in_down_gas_constant == '0) |
                 (in_up_heat_ratio <= cvmf_pkg::ONE_Q16) |
                 (in_down_heat_ratio <= cvmf_pkg::ONE_Q16);
  assign fwd_c = in_down_pressure < in_up_pressure;

  always_ff @(posedge clk) begin
    if (!rst_n) s0_valid_r <= 1'b0;
    else if (en) s0_valid_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_err_r <= err_c;
      s0_fwd_r <= fwd_c;
      if (fwd_c) begin
        s0_p_r   <= in_up_pressure;
        s0_plo_r <= in_down_pressure;
        s0_t_r   <= in_up_temperature;
        s0_g_r   <= in_up_gas_constant;
        s0_h_r   <= in_up_heat_ratio;
        s0_hp1_r <= 18'(in_up_heat_ratio) + 18'(cvmf_pkg::ONE_Q16);
      end else begin
        s0_p_r   <= in_down_pressure;
        s0_plo_r <= in_up_pressure;
        s0_t_r   <= in_down_temperature;
        s0_g_r   <= in_down_gas_constant;
        s0_h_r   <= in_down_heat_ratio;
        s0_hp1_r <= 18'(in_down_heat_ratio) + 18'(cvmf_pkg::ONE_Q16);
      end
    end
  end

  // control word travels the full length
  logic ctl_v, ctl_err, ctl_fwd;
  cvmf_dly #(.W(3), .N(TF)) u_d_ctl (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({s0_valid_r, s0_err_r, s0_fwd_r}), .q({ctl_v, ctl_err, ctl_fwd})
  );

  // ---------------- first log2 bank ----------------
  logic [LW-1:0] lg_p, lg_plo, lg_hp1, lg_h, lg_g, lg_t, lg_a, lg_km1;

  cvmf_log #(.W(24)) u_lg_p   (.clk(clk), .en(en), .x(s0_p_r),        .lg(lg_p));
  cvmf_log #(.W(24)) u_lg_plo (.clk(clk), .en(en), .x(s0_plo_r),      .lg(lg_plo));
  cvmf_log #(.W(18)) u_lg_hp1 (.clk(clk), .en(en), .x(s0_hp1_r),      .lg(lg_hp1));
  cvmf_log #(.W(17)) u_lg_h   (.clk(clk), .en(en), .x(s0_h_r),        .lg(lg_h));
  cvmf_log #(.W(16)) u_lg_g   (.clk(clk), .en(en), .x(s0_g_r),        .lg(lg_g));
  cvmf_log #(.W(16)) u_lg_t   (.clk(clk), .en(en), .x(s0_t_r),        .lg(lg_t));
  cvmf_log #(.W(32)) u_lg_a   (.clk(clk), .en(en), .x(area_r),        .lg(lg_a));
  cvmf_log #(.W(16)) u_lg_km1 (.clk(clk), .en(en), .x(s0_h_r[15:0]),  .lg(lg_km1));

  logic [16:0] hk_h;
  logic [17:0] hk_hp1;
  cvmf_dly #(.W(35), .N(L)) u_d_hk (
    .clk(clk), .rst_n(rst_n), .en(en), .d({s0_h_r, s0_hp1_r}), .q({hk_h, hk_hp1})
  );

  // ---------------- M1: log differences and partial sums ----------------
  logic signed [LW:0]    dl;
  logic [LW-1:0]         lqf;
  logic [LW-1:0]         m1_mr_r;
  logic [23:0]           m1_lq_r;
  logic signed [TW-1:0]  m1_hs_r, m1_totb_r, m1_hsc_r;
  logic [16:0]           m1_h_r;
  logic [17:0]           m1_hp1_r;

  assign dl  = $signed({1'b0, lg_p}) - $signed({1'b0, lg_plo});
  assign lqf = lg_hp1 - LW'(17 << 24);

  always_ff @(posedge clk) begin
    if (en) begin
      m1_mr_r   <= dl[LW] ? '0 : dl[LW-1:0];
      m1_lq_r   <= lqf[23:0];
      m1_hs_r   <= TW'(lg_h) - TW'(lg_g) - TW'(lg_t) - TW'(7 << 24);
      m1_totb_r <= TW'(lg_a) + TW'(lg_p) - TW'(16 << 24);
      m1_hsc_r  <= TW'(lg_h) - TW'(lg_g) - TW'(lg_t) - TW'(lg_hp1) + TW'(9 << 24);
      m1_h_r    <= hk_h;
      m1_hp1_r  <= hk_hp1;
    end
  end

  // ---------------- M2: dividends ----------------
  logic [40:0]   pa;
  logic [46:0]   pb;
  logic [NW-1:0] m2_pa_r, m2_pc_r, m2_pea_r, m2_pb_r;
  logic [DW-1:0] m2_km1_r, m2_h_r;

  assign pa = m1_lq_r * m1_h_r;
  assign pb = m1_mr_r * m1_hp1_r;

  always_ff @(posedge clk) begin
    if (en) begin
      m2_pa_r  <= NW'(pa);
      m2_pc_r  <= NW'({m1_lq_r, 16'b0});
      m2_pea_r <= NW'({m1_mr_r, 17'b0});
      m2_pb_r  <= NW'(pb);
      m2_km1_r <= {1'b0, m1_h_r[15:0]};
      m2_h_r   <= m1_h_r;
    end
  end

  // ---------------- divider bank ----------------
  logic [NW-1:0] q_lrc, q_cq, q_ea, q_eb;

  cvmf_div #(.NW(NW), .DW(DW)) u_div_lrc (
    .clk(clk), .en(en), .n(m2_pa_r),  .d(m2_km1_r), .q(q_lrc));
  cvmf_div #(.NW(NW), .DW(DW)) u_div_cq (
    .clk(clk), .en(en), .n(m2_pc_r),  .d(m2_km1_r), .q(q_cq));
  cvmf_div #(.NW(NW), .DW(DW)) u_div_ea (
    .clk(clk), .en(en), .n(m2_pea_r), .d(m2_h_r),   .q(q_ea));
  cvmf_div #(.NW(NW), .DW(DW)) u_div_eb (
    .clk(clk), .en(en), .n(m2_pb_r),  .d(m2_h_r),   .q(q_eb));

  logic [LW-1:0]        dv_mr;
  logic signed [TW-1:0] dv_hsc, dv_totb;
  cvmf_dly #(.W(LW + 2 * TW), .N(D + 1)) u_d_div (
    .clk(clk), .rst_n(rst_n), .en(en),
    .d({m1_mr_r, m1_hsc_r, m1_totb_r}), .q({dv_mr, dv_hsc, dv_totb})
  );

  // ---------------- X: choke test, choked exponent, subsonic exponents ----------------
  logic signed [TW-1:0] hsc_half;
  logic                 x_ch_r;
  logic signed [TW-1:0] x_totc_r, x_nea_r, x_neb_r;

  assign hsc_half = dv_hsc >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      x_ch_r   <= NW'(dv_mr) >= q_lrc;
      x_totc_r <= dv_totb + hsc_half - $signed(q_cq);
      x_nea_r  <= -$signed(q_ea);
      x_neb_r  <= -$signed(q_eb);
    end
  end

  // ---------------- subsonic pressure-ratio terms ----------------
  logic [EW-1:0] ua, ub;
  cvmf_exp #(.VW(TW), .S(30)) u_exp_a (.clk(clk), .en(en), .v(x_nea_r), .e(ua));
  cvmf_exp #(.VW(TW), .S(30)) u_exp_b (.clk(clk), .en(en), .v(x_neb_r), .e(ub));

  logic [EW-1:0] dab;
  logic          y_dpos_r;
  logic [31:0]   y_d_r;

  assign dab = ua - ub;

  always_ff @(posedge clk) begin
    if (en) begin
      y_dpos_r <= ua > ub;
      y_d_r    <= dab[31:0];
    end
  end

  logic [LW-1:0] lg_d;
  cvmf_log #(.W(32)) u_lg_d (.clk(clk), .en(en), .x(y_d_r), .lg(lg_d));

  // side data aligned to the second log2
  logic [LW-1:0]        lkm1_d;
  logic signed [TW-1:0] hs_d, totb_d, totc_d;
  logic                 ch_d, dpos_d;

  cvmf_dly #(.W(LW), .N(TLD - TL)) u_d_lkm1 (
    .clk(clk), .rst_n(rst_n), .en(en), .d(lg_km1), .q(lkm1_d));
  cvmf_dly #(.W(TW), .N(TLD - TL - 1)) u_d_hs (
    .clk(clk), .rst_n(rst_n), .en(en), .d(m1_hs_r), .q(hs_d));
  cvmf_dly #(.W(TW), .N(TLD - TL)) u_d_totb (
    .clk(clk), .rst_n(rst_n), .en(en), .d(m1_totb_r), .q(totb_d));
  cvmf_dly #(.W(TW + 1), .N(TLD - TD)) u_d_cx (
    .clk(clk), .rst_n(rst_n), .en(en), .d({x_ch_r, x_totc_r}), .q({ch_d, totc_d}));
  cvmf_dly #(.W(1), .N(L + 1)) u_d_dpos (
    .clk(clk), .rst_n(rst_n), .en(en), .d(y_dpos_r), .q(dpos_d));

  // ---------------- Z1/Z2: subsonic sum and path select ----------------
  logic signed [TW-1:0] z1_hsub_r, hsub_half;
  logic signed [TW-1:0] z2_tot_r;
  logic                 z2_zero_r, z2_ch_r;

  always_ff @(posedge clk) begin
    if (en) z1_hsub_r <= hs_d + TW'(lg_d) - TW'(lkm1_d) - TW'(14 << 24);
  end

  assign hsub_half = z1_hsub_r >>> 1;

  always_ff @(posedge clk) begin
    if (en) begin
      z2_tot_r  <= ch_d ? totc_d : totb_d + hsub_half;
      z2_zero_r <= (area_r == '0) | (~ch_d & ~dpos_d);
      z2_ch_r   <= ch_d;
    end
  end

  logic [EW-1:0] mag_e;
  cvmf_exp #(.VW(TW), .S(0)) u_exp_f (.clk(clk), .en(en), .v(z2_tot_r), .e(mag_e));

  logic fin_zero, fin_ch;
  cvmf_dly #(.W(2), .N(E)) u_d_fin (
    .clk(clk), .rst_n(rst_n), .en(en), .d({z2_zero_r, z2_ch_r}), .q({fin_zero, fin_ch}));

  // ---------------- output register: saturate, sign, flags ----------------
  logic [30:0]        magc;
  logic [31:0]        mag32;
  logic               out_valid_r;
  logic signed [31:0] out_mass_flow_r;
  logic               out_is_choked_r, out_input_error_r;

  always_comb begin
    if (ctl_err | fin_zero) magc = '0;
    else if (mag_e > EW'(cvmf_pkg::MASS_CAP)) magc = cvmf_pkg::MASS_CAP;
    else magc = mag_e[30:0];
  end

  assign mag32 = {1'b0, magc};

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= ctl_v;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_mass_flow_r   <= ctl_fwd ? mag32 : 32'd0 - mag32;
      out_is_choked_r   <= ~ctl_err & fin_ch;
      out_input_error_r <= ctl_err;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_mass_flow   = out_mass_flow_r;
  assign out_is_choked   = out_is_choked_r;
  assign out_input_error = out_input_error_r;

endmodule
`default_nettype wire
